>>> src/fltw_pkg.sv
// shared types, constants and helpers of the four-level page table walker
package fltw_pkg;

  // table memory geometry
  localparam int unsigned MEM_WORDS     = 4096;
  localparam int unsigned FRAME_WORDS   = 512;
  localparam int unsigned NUM_FRAMES    = MEM_WORDS / FRAME_WORDS;
  localparam int unsigned ADDR_W        = $clog2(MEM_WORDS);
  localparam int unsigned FRAME_W       = (ADDR_W > 9) ? (ADDR_W - 9) : 1;

  // field widths of one beat
  localparam int unsigned VADDR_W       = 48;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned IDX_W         = 9;

  // entry layout: valid flag and next-table frame field
  localparam int unsigned VALID_BIT     = 0;
  localparam int unsigned FRAME_LSB     = 12;
  localparam int unsigned FRAME_MSB     = 46;
  localparam int unsigned FRAME_FIELD_W = FRAME_MSB - FRAME_LSB + 1;

  // index positions of the four levels
  localparam int unsigned SHIFT_L0      = 39;
  localparam int unsigned SHIFT_L1      = 30;
  localparam int unsigned SHIFT_L2      = 21;
  localparam int unsigned SHIFT_L3      = 12;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_XLATE   = 2'd1,
    CMD_INSTALL = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_MAPPED  = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    LVL_0    = 2'd0,
    LVL_1    = 2'd1,
    LVL_2    = 2'd2,
    LVL_LEAF = 2'd3
  } level_e;

  // one write request into the table memory
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  // nine-bit table index of a virtual address at a given level
  function automatic logic [IDX_W-1:0] level_index(input logic [VADDR_W-1:0] va,
                                                   input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LVL_0:    idx = va[SHIFT_L0 +: IDX_W];
      LVL_1:    idx = va[SHIFT_L1 +: IDX_W];
      LVL_2:    idx = va[SHIFT_L2 +: IDX_W];
      default:  idx = va[SHIFT_L3 +: IDX_W];
    endcase
    return idx;
  endfunction

endpackage

>>> src/fltw_table_mem.sv
// table word memory with a clearing sweep after reset, one write and one read port
module fltw_table_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fltw_pkg::mem_wr_t             wr_i,
  input  logic                          rd_en_i,
  input  logic [fltw_pkg::ADDR_W-1:0]   rd_addr_i,
  output logic [fltw_pkg::WORD_W-1:0]   rd_data_o,
  output logic                          clr_busy_o
);

  logic [fltw_pkg::WORD_W-1:0] mem_q [fltw_pkg::MEM_WORDS];
  logic [fltw_pkg::ADDR_W-1:0] clr_cnt_q;
  logic                        clr_busy_q;
  logic [fltw_pkg::WORD_W-1:0] rd_data_q;

  // clearing sweep: one word per cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + fltw_pkg::ADDR_W'(1);
      if (clr_cnt_q == fltw_pkg::ADDR_W'(fltw_pkg::MEM_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // single write port, the sweep takes it while busy
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

>>> src/four_level_page_table_walker.sv
// top level of the four-level page table walker: sequencer, config and outputs
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------------
//  in      | in  | in_valid_i/in_stall_o  | in_cmd_i, in_addr_i, in_data_i
//  out     | out | out_valid_o/out_stall_i| out_status_o, out_leaf_entry_o,
//          |     |                        | out_stop_level_o
//  cfg     | in  | cfg_we_i               | cfg_wdata_i (root_frame)
//
// table writes and unused commands answer in the cycle after the beat is taken.
// a walk visits each level in the states S_READ (read issue) and S_CHECK (entry
// check), after the accept in S_IDLE; the table memory has a single read port.
// after reset a clearing sweep zeroes all MEM_WORDS words of the table, one word
// a cycle; no beat is taken meanwhile, config writes are.
// one item is in flight at a time; a new beat is taken once the result register
// is empty or being drained in the same cycle.
module four_level_page_table_walker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_cmd_i,
  input  logic [fltw_pkg::VADDR_W-1:0]  in_addr_i,
  input  logic [fltw_pkg::WORD_W-1:0]   in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    out_status_o,
  output logic [fltw_pkg::WORD_W-1:0]   out_leaf_entry_o,
  output logic [1:0]                    out_stop_level_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK
  } state_e;

  state_e                             state_q;
  logic [2:0]                         root_frame_q;
  logic [1:0]                         level_q;
  logic                               install_q;
  logic [fltw_pkg::VADDR_W-1:0]       addr_q;
  logic [fltw_pkg::WORD_W-1:0]        data_q;
  logic [fltw_pkg::FRAME_W-1:0]       frame_q;
  logic                               out_valid_q;
  logic [1:0]                         out_status_q;
  logic [fltw_pkg::WORD_W-1:0]        out_leaf_q;
  logic [1:0]                         out_level_q;

  logic                               clr_busy;
  logic                               accept;
  logic                               out_free;
  logic                               wr_in_range;
  logic                               root_ok;
  logic [fltw_pkg::ADDR_W-1:0]        slot;
  logic [fltw_pkg::WORD_W-1:0]        mem_rd_data;
  logic [fltw_pkg::WORD_W-1:0]        entry;
  logic                               entry_valid;
  logic [fltw_pkg::FRAME_FIELD_W-1:0] next_frame;
  logic                               next_ok;
  logic                               leaf_fill;
  logic                               walk_cmd;
  logic                               out_load;
  fltw_pkg::mem_wr_t                  mem_wr;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_frame_q <= '0;
    end else if (cfg_we_i) begin
      root_frame_q <= cfg_wdata_i;
    end
  end

  // input handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == S_IDLE && !clr_busy && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // range checks of the incoming beat, the root frame and the next-level frame
  assign wr_in_range = in_addr_i < fltw_pkg::VADDR_W'(fltw_pkg::MEM_WORDS);
  assign root_ok     = fltw_pkg::FRAME_FIELD_W'(root_frame_q)
                       < fltw_pkg::FRAME_FIELD_W'(fltw_pkg::NUM_FRAMES);
  assign entry       = mem_rd_data;
  assign entry_valid = entry[fltw_pkg::VALID_BIT];
  assign next_frame  = entry[fltw_pkg::FRAME_MSB:fltw_pkg::FRAME_LSB];
  assign next_ok     = next_frame < fltw_pkg::FRAME_FIELD_W'(fltw_pkg::NUM_FRAMES);

  // word address of the current level's slot
  assign slot = fltw_pkg::ADDR_W'({frame_q, fltw_pkg::level_index(addr_q, level_q)});

  // leaf install into an empty slot
  assign leaf_fill = state_q == S_CHECK && level_q == fltw_pkg::LVL_LEAF
                     && install_q && !entry_valid;

  // a result is loaded into the output register at this edge
  assign walk_cmd = in_cmd_i inside {fltw_pkg::CMD_XLATE, fltw_pkg::CMD_INSTALL};
  assign out_load = (accept && (!walk_cmd || !root_ok))
                    || (state_q == S_CHECK
                        && (level_q == fltw_pkg::LVL_LEAF || !entry_valid || !next_ok));

  // memory write port: table write beat or leaf install
  always_comb begin
    mem_wr.en   = 1'b0;
    mem_wr.addr = in_addr_i[fltw_pkg::ADDR_W-1:0];
    mem_wr.data = in_data_i;
    if (accept && in_cmd_i == fltw_pkg::CMD_WRITE && wr_in_range) begin
      mem_wr.en = 1'b1;
    end else if (leaf_fill) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = slot;
      mem_wr.data = data_q;
    end
  end

  fltw_table_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (mem_wr),
    .rd_en_i    (state_q == S_READ),
    .rd_addr_i  (slot),
    .rd_data_o  (mem_rd_data),
    .clr_busy_o (clr_busy)
  );

  // walk sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      level_q      <= fltw_pkg::LVL_0;
      install_q    <= 1'b0;
      frame_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= fltw_pkg::ST_OK;
      out_leaf_q   <= '0;
      out_level_q  <= fltw_pkg::LVL_0;
      addr_q       <= '0;
      data_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            out_leaf_q  <= '0;
            out_level_q <= fltw_pkg::LVL_0;
            case (in_cmd_i) inside
              fltw_pkg::CMD_WRITE: begin
                out_status_q <= wr_in_range ? fltw_pkg::ST_OK : fltw_pkg::ST_RANGE;
              end
              fltw_pkg::CMD_XLATE, fltw_pkg::CMD_INSTALL: begin
                install_q <= in_cmd_i == fltw_pkg::CMD_INSTALL;
                addr_q    <= in_addr_i;
                data_q    <= in_data_i;
                level_q   <= fltw_pkg::LVL_0;
                frame_q   <= fltw_pkg::FRAME_W'(root_frame_q);
                if (root_ok) begin
                  state_q <= S_READ;
                end else begin
                  out_status_q <= fltw_pkg::ST_RANGE;
                end
              end
              default: begin
                out_status_q <= fltw_pkg::ST_OK;
              end
            endcase
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (level_q == fltw_pkg::LVL_LEAF) begin
            state_q     <= S_IDLE;
            out_level_q <= fltw_pkg::LVL_LEAF;
            if (!install_q) begin
              out_status_q <= entry_valid ? fltw_pkg::ST_OK : fltw_pkg::ST_INVALID;
              out_leaf_q   <= entry_valid ? entry : '0;
            end else begin
              out_status_q <= entry_valid ? fltw_pkg::ST_MAPPED : fltw_pkg::ST_OK;
            end
          end else if (!entry_valid) begin
            state_q      <= S_IDLE;
            out_status_q <= fltw_pkg::ST_INVALID;
            out_level_q  <= level_q;
          end else if (!next_ok) begin
            state_q      <= S_IDLE;
            out_status_q <= fltw_pkg::ST_RANGE;
            out_level_q  <= level_q + 2'd1;
          end else begin
            state_q <= S_READ;
            level_q <= level_q + 2'd1;
            frame_q <= next_frame[fltw_pkg::FRAME_W-1:0];
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_leaf_entry_o = out_leaf_q;
  assign out_stop_level_o = out_level_q;

  // a leaf entry is only reported by a successful walk to the last level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_leaf_entry_o != '0
    |-> out_status_o == fltw_pkg::ST_OK && out_stop_level_o == fltw_pkg::LVL_LEAF)
    else $error("leaf entry reported on a failed or short walk");

  // the result register stays empty while a walk is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !out_valid_q)
    else $error("result register busy during a walk");

  // each new read after a check moves one level down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK ##1 state_q == S_READ |-> level_q == $past(level_q) + 2'd1)
    else $error("walk level did not advance by one");

  // nothing is taken or written while the table is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !accept && !leaf_fill && state_q == S_IDLE)
    else $error("activity during the clearing sweep");

endmodule
